/* src/srb_pkg.sv */
// Shared types and constants for the sequence reorder buffer.
// Used by srb_cell and sequence_reorder_buffer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

    localparam int STORE_CAP = 20;
    localparam int SLOTS     = STORE_CAP + 1;
    localparam int SEQ_W     = 32;
    localparam int HANDLE_W  = 16;
    localparam int ACTION_W  = 2;
    localparam int TDATA_W   = ((SEQ_W + HANDLE_W + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FWD  = 2'd0,
        ACT_LATE = 2'd1,
        ACT_DUP  = 2'd2
    } t_action;

    typedef struct packed {
        logic                valid;
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic insert;   // place new entry in sorted position
        logic replace;  // overwrite handle of the matching entry
        logic shift;    // pop head, every cell takes its right neighbor
    } t_cell_ctl;

endpackage

`default_nettype wire

/* src/srb_cell.sv */
// One cell of the sorted entry chain: holds one entry, compares it with the
// incoming key and trades entries with its neighbors. Depends on srb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srb_cell
    import srb_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cell_ctl           i_ctl,
    input  wire logic [SEQ_W-1:0]    i_key,
    input  wire logic [HANDLE_W-1:0] i_handle,
    input  wire t_entry              i_left,
    input  wire logic                i_left_lt,
    input  wire t_entry              i_right,
    output t_entry                   o_entry,
    output logic                     o_lt,
    output logic                     o_eq
);

    t_entry r_entry;
    t_entry n_entry;

    assign o_entry = r_entry;
    assign o_lt    = !r_entry.valid || (i_key < r_entry.seq);
    assign o_eq    = r_entry.valid && (r_entry.seq == i_key);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_entry = i_right;
        end else if (i_ctl.replace) begin
            if (o_eq) begin
                n_entry.handle = i_handle;
            end
        end else if (i_ctl.insert && o_lt) begin
            // left neighbor also larger: move it in, else this is the spot
            if (i_left_lt) begin
                n_entry = i_left;
            end else begin
                n_entry.valid  = 1'b1;
                n_entry.seq    = i_key;
                n_entry.handle = i_handle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

`default_nettype wire

/* src/sequence_reorder_buffer.sv */
// Top level of the sequence reorder buffer: next-expected tracking, output
// register and a sorted chain of srb_cell instances. Depends on srb_pkg.
//
//  channel | dir | tdata (low bit up)            | tuser   | tlast
//  --------+-----+-------------------------------+---------+------------
//  s       | in  | seq_number[31:0], handle[15:0]| -       | -
//  m       | out | out_handle[15:0], out_seq[31:0]| action | last_of_run
//
// An in-order, late or duplicate word is loaded into the output register; an
// early word is stored in the chain. A run released from the chain drains one
// word per cycle from the head cell while the output register is free, and the
// input is held until the run ends. One output register separates the sides;
// input is taken when it is empty or being read and no run is draining. Reset
// is synchronous and clears the chain valid bits and next expected number.
`timescale 1ns / 1ps
`default_nettype none

module sequence_reorder_buffer
    import srb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [TDATA_W-1:0] i_s_tdata,   // seq_number, packet_handle
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [TDATA_W-1:0]      o_m_tdata,   // out_handle, out_seq
    output logic [ACTION_W-1:0]     o_m_tuser,   // action
    output logic                    o_m_tlast    // last_of_run
);

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } t_state;

    t_state r_state;

    logic [SEQ_W-1:0]    r_next;
    logic                r_out_valid;
    logic [SEQ_W-1:0]    r_out_seq;
    logic [HANDLE_W-1:0] r_out_handle;
    t_action             r_out_action;
    logic                r_out_last;

    logic [SEQ_W-1:0]    in_seq;
    logic [HANDLE_W-1:0] in_handle;
    logic [SEQ_W-1:0]    seq_inc;
    logic [SEQ_W-1:0]    head_inc;
    logic                out_free;
    logic                accept;
    logic                is_match;
    logic                is_late;
    logic                any_eq;
    logic                out_load;
    logic [HANDLE_W-1:0] dup_handle;
    logic                cont_in;
    logic                cont_drain;
    t_cell_ctl           cell_ctl;

    t_entry              cells [SLOTS];
    logic [SLOTS-1:0]    cell_lt;
    logic [SLOTS-1:0]    cell_eq;

    assign in_seq    = i_s_tdata[SEQ_W-1:0];
    assign in_handle = i_s_tdata[SEQ_W +: HANDLE_W];
    assign seq_inc   = in_seq + 1'b1;
    assign head_inc  = cells[0].seq + 1'b1;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;
    assign is_match   = (in_seq == r_next);
    assign is_late    = (in_seq < r_next);
    assign any_eq     = |cell_eq;
    assign out_load   = ((r_state == S_DRAIN) && out_free)
                        || (accept && (is_match || is_late || any_eq));

    // chain is sorted and unique, so a run continues only at the next cell
    assign cont_in    = cells[0].valid && (cells[0].seq == seq_inc);
    assign cont_drain = cells[1].valid && (cells[1].seq == head_inc);

    always_comb begin
        dup_handle = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (cell_eq[i]) begin
                dup_handle = dup_handle | cells[i].handle;
            end
        end
    end

    always_comb begin
        cell_ctl.insert  = accept && !is_match && !is_late && !any_eq;
        cell_ctl.replace = accept && !is_match && !is_late && any_eq;
        cell_ctl.shift   = (r_state == S_DRAIN) && out_free;
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        t_entry left_entry;
        t_entry right_entry;
        logic   left_lt;

        if (g == 0) begin : g_first
            assign left_entry = '0;
            assign left_lt    = 1'b0;
        end else begin : g_mid
            assign left_entry = cells[g-1];
            assign left_lt    = cell_lt[g-1];
        end

        if (g == SLOTS - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = cells[g+1];
        end

        srb_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (cell_ctl),
            .i_key    (in_seq),
            .i_handle (in_handle),
            .i_left   (left_entry),
            .i_left_lt(left_lt),
            .i_right  (right_entry),
            .o_entry  (cells[g]),
            .o_lt     (cell_lt[g]),
            .o_eq     (cell_eq[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (is_match) begin
                            r_out_seq    <= in_seq;
                            r_out_handle <= in_handle;
                            r_out_action <= ACT_FWD;
                            r_out_last   <= !cont_in;
                            r_next       <= seq_inc;
                            if (cont_in) begin
                                r_state <= S_DRAIN;
                            end
                        end else if (is_late) begin
                            r_out_seq    <= in_seq;
                            r_out_handle <= in_handle;
                            r_out_action <= ACT_LATE;
                            r_out_last   <= 1'b1;
                        end else if (any_eq) begin
                            r_out_seq    <= in_seq;
                            r_out_handle <= dup_handle;
                            r_out_action <= ACT_DUP;
                            r_out_last   <= 1'b1;
                        end else if (cells[STORE_CAP-1].valid) begin
                            // table overflows: jump to the smallest entry and release its run
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (out_free) begin
                        r_out_seq    <= cells[0].seq;
                        r_out_handle <= cells[0].handle;
                        r_out_action <= ACT_FWD;
                        r_out_last   <= !cont_drain;
                        r_next       <= head_inc;
                        if (!cont_drain) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_W'({r_out_seq, r_out_handle});
    assign o_m_tuser  = r_out_action;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire
